FILE: src/qtd_pkg.sv
// shared types and constants of the quadtree image decoder
package qtd_pkg;

  // stream tag bytes
  localparam logic [7:0] TAG_NODE = 8'h4E;
  localparam logic [7:0] TAG_LEAF = 8'h48;

  // power-up width of the image, log2
  localparam logic [3:0] WIDTH_LOG2_RESET = 4'd8;

  // quadrant code of the last (bottom-right) child
  localparam logic [1:0] QUAD_LAST = 2'd3;

  // which byte of the stream comes next
  typedef enum logic [1:0] {
    PH_TAG   = 2'd0,
    PH_RED   = 2'd1,
    PH_GREEN = 2'd2,
    PH_BLUE  = 2'd3
  } qtd_phase_t;

  // sequencer states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_POP  = 1'b1
  } qtd_state_t;

  // commands from the sequencer to the quadrant stack
  typedef struct packed {
    logic load;  // store the clamped depth
    logic push;  // open a new level with quadrant top-left
    logic pop;   // drop the finished top level
    logic bump;  // step the top level to its next quadrant
  } qtd_stk_ctl_t;

  // status from the quadrant stack
  typedef struct packed {
    logic empty;     // no level open
    logic top_last;  // top level sits on its last quadrant
  } qtd_stk_sts_t;

endpackage

FILE: src/qtd_stack.sv
// quadrant stack with depth counter and leaf position decode
module qtd_stack #(
  parameter int MAX_WIDTH_LOG2 = 10
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [3:0]                         w_eff,
  input  qtd_pkg::qtd_stk_ctl_t              ctl,
  output logic [$clog2(MAX_WIDTH_LOG2+1)-1:0] eff_depth,
  output qtd_pkg::qtd_stk_sts_t              sts,
  output logic [9:0]                         pos_x,
  output logic [9:0]                         pos_y
);
  import qtd_pkg::*;

  localparam int DW = $clog2(MAX_WIDTH_LOG2 + 1);
  localparam int IW = (MAX_WIDTH_LOG2 > 1) ? $clog2(MAX_WIDTH_LOG2) : 1;

  logic [1:0]      stack_r [MAX_WIDTH_LOG2];
  logic [DW-1:0]   depth_r, depth_nxt;
  logic [DW-1:0]   w_d;
  logic [DW-1:0]   depth_m1;
  logic [1:0]      top_q;
  logic [MAX_WIDTH_LOG2+9:0] px_full, py_full;

  // depth clamped to the current image width
  assign w_d       = w_eff[DW-1:0];
  assign eff_depth = (depth_r > w_d) ? w_d : depth_r;

  // top of stack
  assign depth_m1 = depth_r - 1'b1;
  assign top_q    = stack_r[depth_m1[IW-1:0]];

  assign sts.empty    = (depth_r == '0);
  assign sts.top_last = (depth_r != '0) && (top_q == QUAD_LAST);

  // depth update
  always_comb begin
    depth_nxt = depth_r;
    if (ctl.push) begin
      depth_nxt = eff_depth + 1'b1;
    end else if (ctl.load) begin
      depth_nxt = eff_depth;
    end else if (ctl.pop) begin
      depth_nxt = depth_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else begin
      depth_r <= depth_nxt;
    end
  end

  // stack entries, only read below the depth
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      stack_r[eff_depth[IW-1:0]] <= '0;
    end else if (ctl.bump) begin
      stack_r[depth_m1[IW-1:0]] <= top_q + 2'd1;
    end
  end

  // position: level l places its quadrant bits at w - l
  always_comb begin
    int j;
    px_full = '0;
    py_full = '0;
    for (int l = 1; l <= MAX_WIDTH_LOG2; l++) begin
      j = int'(w_eff) - l;
      if (l <= int'(eff_depth) && j >= 0) begin
        px_full[j] = stack_r[l-1][0];
        py_full[j] = stack_r[l-1][1];
      end
    end
  end

  assign pos_x = px_full[9:0];
  assign pos_y = py_full[9:0];

endmodule

FILE: src/quadtree_image_decoder_unit.sv
// top level of the quadtree image decoder
//
// Takes a preorder quadtree stream one byte per beat on in_code_byte
// (valid/ready) and emits one beat per leaf square on the out_ channel:
// position, log2 size and color, plus tree_done on the beat that closes the
// tree and depth_error for a node tag at the deepest level.
// cfg_we/cfg_wdata set log2 of the image width (reset 8, capped at
// MAX_WIDTH_LOG2); a write takes effect at the next byte.
// Node and leaf tags and color bytes need no further work. After a leaf's
// blue byte, an empty quadrant or a deepest-level node, the sequencer pops
// the finished levels off the quadrant stack, one per cycle, and then steps
// to its next quadrant; the beat shows on out_valid in the cycle after.
// The block takes no byte while popping, nor while a result beat waits
// on out_ready, so a stalled receiver holds off the input side.
// Reset (rst_n low, synchronous) returns to the root tag of a new tree
// with an empty stack and clears any pending result beat.
module quadtree_image_decoder_unit #(
  parameter int MAX_WIDTH_LOG2 = 10
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_code_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [9:0] out_pos_x,
  output logic [9:0] out_pos_y,
  output logic [3:0] out_size_log2,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic       out_tree_done,
  output logic       out_depth_error
);
  import qtd_pkg::*;

  localparam int DW = $clog2(MAX_WIDTH_LOG2 + 1);

  qtd_state_t   state_r, state_nxt;
  qtd_phase_t   phase_r, phase_nxt;
  logic [3:0]   width_log2_r;
  logic [3:0]   w_eff;
  logic [7:0]   red_hold_r, green_hold_r;
  logic         emit_r, emit_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic         done_r, done_nxt;
  logic         capture;
  logic         capture_err;
  logic         accept;
  logic         at_bottom;
  logic [DW-1:0] eff_depth;
  logic [3:0]   eff_depth_ext;
  logic [9:0]   place_x, place_y;
  qtd_stk_ctl_t stk_ctl;
  qtd_stk_sts_t stk_sts;

  logic [9:0]   pos_x_r, pos_y_r;
  logic [3:0]   size_r;
  logic [7:0]   red_r, green_r, blue_r;
  logic         err_r;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_log2_r <= WIDTH_LOG2_RESET;
    end else if (cfg_we) begin
      width_log2_r <= cfg_wdata;
    end
  end

  assign w_eff = (width_log2_r > 4'(MAX_WIDTH_LOG2)) ? 4'(MAX_WIDTH_LOG2) : width_log2_r;

  qtd_stack #(
    .MAX_WIDTH_LOG2(MAX_WIDTH_LOG2)
  ) u_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .w_eff     (w_eff),
    .ctl       (stk_ctl),
    .eff_depth (eff_depth),
    .sts       (stk_sts),
    .pos_x     (place_x),
    .pos_y     (place_y)
  );

  assign eff_depth_ext = 4'(eff_depth);
  assign at_bottom     = (eff_depth_ext >= w_eff);

  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    emit_nxt      = emit_r;
    out_valid_nxt = out_valid_r && !out_ready;
    done_nxt      = done_r;
    capture       = 1'b0;
    capture_err   = 1'b0;
    stk_ctl       = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (phase_r)
            PH_TAG: begin
              if (in_code_byte == TAG_NODE) begin
                if (at_bottom) begin
                  stk_ctl.load = 1'b1;
                  capture      = 1'b1;
                  capture_err  = 1'b1;
                  emit_nxt     = 1'b1;
                  state_nxt    = ST_POP;
                end else begin
                  stk_ctl.push = 1'b1;
                end
              end else if (in_code_byte == TAG_LEAF) begin
                stk_ctl.load = 1'b1;
                phase_nxt    = PH_RED;
              end else begin
                // empty quadrant
                stk_ctl.load = 1'b1;
                emit_nxt     = 1'b0;
                state_nxt    = ST_POP;
              end
            end
            PH_RED: begin
              stk_ctl.load = 1'b1;
              phase_nxt    = PH_GREEN;
            end
            PH_GREEN: begin
              stk_ctl.load = 1'b1;
              phase_nxt    = PH_BLUE;
            end
            PH_BLUE: begin
              stk_ctl.load = 1'b1;
              capture      = 1'b1;
              emit_nxt     = 1'b1;
              state_nxt    = ST_POP;
            end
            default: begin
              phase_nxt = PH_TAG;
            end
          endcase
        end
      end
      ST_POP: begin
        // one finished level per cycle, then step to the next quadrant
        if (stk_sts.top_last) begin
          stk_ctl.pop = 1'b1;
        end else begin
          stk_ctl.bump = !stk_sts.empty;
          phase_nxt    = PH_TAG;
          state_nxt    = ST_IDLE;
          if (emit_r) begin
            out_valid_nxt = 1'b1;
            done_nxt      = stk_sts.empty;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_TAG;
      emit_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      emit_r      <= emit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // color holds and result payload
  always_ff @(posedge clk) begin
    done_r <= done_nxt;
    if (accept && phase_r == PH_RED) begin
      red_hold_r <= in_code_byte;
    end
    if (accept && phase_r == PH_GREEN) begin
      green_hold_r <= in_code_byte;
    end
    if (capture) begin
      pos_x_r <= place_x;
      pos_y_r <= place_y;
      err_r   <= capture_err;
      if (capture_err) begin
        size_r  <= '0;
        red_r   <= '0;
        green_r <= '0;
        blue_r  <= '0;
      end else begin
        size_r  <= w_eff - eff_depth_ext;
        red_r   <= red_hold_r;
        green_r <= green_hold_r;
        blue_r  <= in_code_byte;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pos_x       = pos_x_r;
  assign out_pos_y       = pos_y_r;
  assign out_size_log2   = size_r;
  assign out_red         = red_r;
  assign out_green       = green_r;
  assign out_blue        = blue_r;
  assign out_tree_done   = done_r;
  assign out_depth_error = err_r;

endmodule

FILE: tb/tb.sv
// self-checking testbench for the quadtree image decoder unit
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import qtd_pkg::*;

  localparam int unsigned MAXW = 10;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned SETTLE_CYCLES = 40;

  // one leaf square as it leaves the block
  typedef struct packed {
    logic [9:0] pos_x;
    logic [9:0] pos_y;
    logic [3:0] size_log2;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       tree_done;
    logic       depth_error;
  } leaf_beat_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [3:0] cfg_wdata = 4'd0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_code_byte = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [9:0] out_pos_x;
  logic [9:0] out_pos_y;
  logic [3:0] out_size_log2;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       out_tree_done;
  logic       out_depth_error;

  quadtree_image_decoder_unit #(.MAX_WIDTH_LOG2(MAXW)) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_code_byte   (in_code_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pos_x      (out_pos_x),
    .out_pos_y      (out_pos_y),
    .out_size_log2  (out_size_log2),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_tree_done  (out_tree_done),
    .out_depth_error(out_depth_error)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [7:0]  byte_q[$];   // stream bytes still to be sent
  leaf_beat_t  leaf_q[$];   // leaf squares the block still owes
  int unsigned fail_count = 0;
  int unsigned cycles = 0;
  int unsigned n_in = 0;
  logic        in_taken = 1'b0;
  bit          calm;

  // decoder shadow state
  logic [3:0]  w_reg;
  qtd_phase_t  phase;
  int unsigned depth;
  logic [1:0]  quad [0:MAXW];
  logic [7:0]  red_h;
  logic [7:0]  green_h;

  // no idling on either side for a stretch of beats
  assign calm = (n_in >= 500) && (n_in < 650);

  // top-left corner of the current quadrant, {y, x}
  function automatic logic [19:0] quad_origin(int unsigned w, int unsigned d);
    int unsigned px, py;
    px = 0;
    py = 0;
    for (int unsigned l = 1; l <= d; l++) begin
      px |= int'(quad[l-1][0]) << (w - l);
      py |= int'(quad[l-1][1]) << (w - l);
    end
    return {py[9:0], px[9:0]};
  endfunction

  // finish the current quadrant; 1 when the whole tree is closed
  function automatic bit close_quadrant();
    while (depth > 0 && quad[depth-1] == QUAD_LAST) depth--;
    phase = PH_TAG;
    if (depth == 0) return 1'b1;
    quad[depth-1] = quad[depth-1] + 2'd1;
    return 1'b0;
  endfunction

  // advance the shadow decoder by one stream byte
  task automatic decode_byte(input logic [7:0] b, output bit has, output leaf_beat_t r);
    int unsigned w, d;
    logic [19:0] org;
    w = (w_reg > MAXW) ? MAXW : w_reg;
    if (depth > w) depth = w;
    d = depth;
    has = 1'b0;
    r = '0;
    case (phase)
      PH_TAG: begin
        if (b == TAG_NODE) begin
          if (d >= w) begin
            // node at the deepest level opens nothing
            org = quad_origin(w, d);
            has = 1'b1;
            r.pos_x = org[9:0];
            r.pos_y = org[19:10];
            r.depth_error = 1'b1;
            r.tree_done = close_quadrant();
          end else begin
            quad[d] = 2'd0;
            depth = d + 1;
          end
        end else if (b == TAG_LEAF) begin
          phase = PH_RED;
        end else begin
          void'(close_quadrant());
        end
      end
      PH_RED: begin
        red_h = b;
        phase = PH_GREEN;
      end
      PH_GREEN: begin
        green_h = b;
        phase = PH_BLUE;
      end
      default: begin
        org = quad_origin(w, d);
        has = 1'b1;
        r.pos_x = org[9:0];
        r.pos_y = org[19:10];
        r.size_log2 = 4'((w - d) & 4'hF);
        r.red = red_h;
        r.green = green_h;
        r.blue = b;
        r.tree_done = close_quadrant();
      end
    endcase
  endtask

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // stimulus builders
  task automatic push_leaf();
    byte_q.push_back(TAG_LEAF);
    repeat (3) byte_q.push_back(8'($urandom_range(255)));
  endtask

  task automatic push_empty();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    while (b == TAG_NODE || b == TAG_LEAF) b = 8'($urandom_range(255));
    byte_q.push_back(b);
  endtask

  // well-formed subtree; a spine forces one child open down to the deepest level
  task automatic gen_tree(int unsigned lvl, int unsigned w, bit spine);
    int unsigned pick, k;
    pick = $urandom_range(99);
    k = $urandom_range(3);
    if (lvl >= w) begin
      if (pick < 70) push_leaf();
      else if (pick < 85) push_empty();
      else byte_q.push_back(TAG_NODE);
    end else if (spine || pick < ((lvl == 0) ? 50 : 20)) begin
      byte_q.push_back(TAG_NODE);
      for (int unsigned i = 0; i < 4; i++) gen_tree(lvl + 1, w, spine && (i == k));
    end else if (pick < 75) begin
      push_leaf();
    end else begin
      push_empty();
    end
  endtask

  // wait until every byte is in and every leaf is out, then let the block settle
  task automatic wait_idle();
    @(posedge clk);
    #1;
    while (byte_q.size() != 0 || in_valid || leaf_q.size() != 0) begin
      @(posedge clk);
      #1;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_width(logic [3:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    w_reg = v;
  endtask

  // input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (byte_q.size() != 0 && (calm || $urandom_range(99) >= 24)) begin
        in_code_byte <= byte_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver with two long hold-offs
  int unsigned hold_left = 0;
  int unsigned hold_no = 0;
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_no < 2 && n_in >= ((hold_no == 0) ? 330 : 800)) begin
      hold_no++;
      hold_left = 250;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 24);
    end
  end

  // monitor: check result beats, then predict from accepted bytes
  leaf_beat_t mon_want, mon_next;
  bit         mon_has;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (leaf_q.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count++;
        end else begin
          mon_want = leaf_q.pop_front();
          check_field("pos_x", mon_want.pos_x, out_pos_x);
          check_field("pos_y", mon_want.pos_y, out_pos_y);
          check_field("size_log2", mon_want.size_log2, out_size_log2);
          check_field("red", mon_want.red, out_red);
          check_field("green", mon_want.green, out_green);
          check_field("blue", mon_want.blue, out_blue);
          check_field("tree_done", mon_want.tree_done, out_tree_done);
          check_field("depth_error", mon_want.depth_error, out_depth_error);
        end
      end
      if (in_valid && in_ready) begin
        decode_byte(in_code_byte, mon_has, mon_next);
        if (mon_has) leaf_q.push_back(mon_next);
        n_in <= n_in + 1;
      end
    end
    in_taken <= rst_n && in_valid && in_ready;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[quadtree_image_decoder_unit] ERROR");
      $finish;
    end
  end

  // test sequence
  int unsigned plan_w[$] = '{10, 1, 2, 3, 4, 5, 6, 7, 9, 15, 0, 11};
  int unsigned kind, start, w_eff;
  initial begin
    w_reg = WIDTH_LOG2_RESET;
    phase = PH_TAG;
    depth = 0;
    foreach (quad[i]) quad[i] = 2'd0;
    red_h = 8'd0;
    green_h = 8'd0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // reset width: whole-image leaf, then one level with empty quadrants
    byte_q = '{TAG_LEAF, 8'h00, 8'h00, 8'h00,
               TAG_NODE, TAG_LEAF, 8'hFF, 8'hFF, 8'hFF, 8'h00,
               TAG_LEAF, 8'h12, 8'h34, 8'h56, 8'hFF};
    wait_idle();

    // zero width: root node is already at the deepest level
    set_width(4'd0);
    byte_q = '{TAG_NODE, TAG_LEAF, 8'h01, 8'h02, 8'h03};
    wait_idle();

    // oversized width, stream left mid-tree
    set_width(4'd15);
    byte_q = '{TAG_NODE, 8'h4D, TAG_LEAF, 8'hAA, 8'h55, 8'hC3};
    wait_idle();

    // shrink the width mid-tree so the next node tag sits at the deepest level
    set_width(4'd1);
    byte_q = '{TAG_NODE, TAG_LEAF, 8'h80, 8'h40, 8'h20};
    wait_idle();

    // random phases, one width setting each
    plan_w.push_back($urandom_range(15));
    plan_w.push_back($urandom_range(15));
    foreach (plan_w[p]) begin
      set_width(4'(plan_w[p]));
      w_eff = (plan_w[p] > MAXW) ? MAXW : plan_w[p];
      while (byte_q.size() < 70) begin
        kind = $urandom_range(99);
        start = byte_q.size();
        if (kind < 10) begin
          repeat ($urandom_range(1, 4)) byte_q.push_back(8'($urandom_range(255)));
        end else begin
          gen_tree(0, w_eff, $urandom_range(99) < 30);
          // broken tree: cut the tail off
          if (kind < 20) repeat ($urandom_range(1, byte_q.size() - start)) void'(byte_q.pop_back());
        end
      end
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("[quadtree_image_decoder_unit] OK");
    end else begin
      $display("[quadtree_image_decoder_unit] ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
src/qtd_pkg.sv
src/qtd_stack.sv
src/quadtree_image_decoder_unit.sv
tb/tb.sv
